// ----- rtl/tbcfr_pkg.sv -----
`default_nettype none

package tbcfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned POINT_W    = 10;
    localparam int unsigned ZERO_W     = 11;
    localparam int unsigned STEP_W     = 24;
    localparam int unsigned CURRENT_W  = 36;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned RESULT_W   = 192;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAMING_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_POINT_X2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Q16      = 2'd2;

    localparam logic [BYTE_W-1:0] FRAMING_MASK_RST  = 8'h01;
    localparam logic [ZERO_W-1:0] ZERO_POINT_X2_RST = 11'd1023;
    localparam logic [STEP_W-1:0] STEP_Q16_RST      = 24'd65536;

    localparam logic [3:0] CHECK_MATCH = 4'hF;

    typedef enum logic [1:0] {
        OUTCOME_INCOMPLETE = 2'd0,
        OUTCOME_NO_START   = 2'd1,
        OUTCOME_OK         = 2'd2,
        OUTCOME_BAD_CHECK  = 2'd3
    } t_outcome;

    typedef struct packed {
        logic [BYTE_W-1:0] framing_mask;
        logic [ZERO_W-1:0] zero_point_x2;
        logic [STEP_W-1:0] step_q16;
    } t_cfg;

    // last member sits in the lowest bits, matching the tdata layout
    typedef struct packed {
        logic [COUNT_W-1:0]          wrong_total;
        logic [COUNT_W-1:0]          incomplete_total;
        logic [COUNT_W-1:0]          message_total;
        logic [COUNT_W-1:0]          packet_total;
        logic signed [CURRENT_W-1:0] current_q16;
        logic [POINT_W-1:0]          scale_point;
        logic [BYTE_W-1:0]           second_packet;
        logic [BYTE_W-1:0]           first_packet;
        t_outcome                    outcome;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/two_byte_current_frame_receiver.sv -----
// an accepted word is held in the input register, its result in the result register
// throughput: one word per cycle while the master side takes results; the decode and
//   the 12 x 25 bit multiply sit between the input register and the result register
// two words are held when the master side stalls: one in each register
// reset: synchronous active low, clears counters and message state and loads the
//   register defaults (framing mask 0x01, zero point 1023 half steps, step 1.0)
`default_nettype none

module two_byte_current_frame_receiver (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // rx_byte
    input  wire logic [tbcfr_pkg::BYTE_W-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // outcome, first_packet, second_packet, scale_point, current_q16,
    // packet_total, message_total, incomplete_total, wrong_total
    output logic [tbcfr_pkg::RESULT_W-1:0]            m_axis_tdata,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tbcfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tbcfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                               r_in_valid;
    logic [tbcfr_pkg::BYTE_W-1:0]       r_in_byte;
    logic                               r_out_valid;
    tbcfr_pkg::t_result                 r_out_data;

    tbcfr_pkg::t_cfg                    cfg;
    tbcfr_pkg::t_result                 result;
    logic                               commit;

    assign commit        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || commit;

    tbcfr_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tbcfr_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> m_axis_tvalid)
        else $error("committed word not presented");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("slave side stalled with room left");

    a_zero_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.outcome != tbcfr_pkg::OUTCOME_OK)
            |-> (r_out_data.current_q16 == '0 && r_out_data.scale_point == '0))
        else $error("current reported without a decoded message");

    a_packet_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && $past(commit) && $past(i_rst_n))
            |=> r_out_data.packet_total == $past(r_out_data.packet_total) + 1'b1)
        else $error("packet total did not advance by one");
`endif

endmodule

`default_nettype wire

// ----- rtl/tbcfr_cfg_regs.sv -----
`default_nettype none

module tbcfr_cfg_regs (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [tbcfr_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tbcfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output tbcfr_pkg::t_cfg                           o_cfg
);

    tbcfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.framing_mask  <= tbcfr_pkg::FRAMING_MASK_RST;
            r_cfg.zero_point_x2 <= tbcfr_pkg::ZERO_POINT_X2_RST;
            r_cfg.step_q16      <= tbcfr_pkg::STEP_Q16_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tbcfr_pkg::CFG_FRAMING_MASK: begin
                    r_cfg.framing_mask <= i_cfg_data[tbcfr_pkg::BYTE_W-1:0];
                end
                tbcfr_pkg::CFG_ZERO_POINT_X2: begin
                    r_cfg.zero_point_x2 <= i_cfg_data[tbcfr_pkg::ZERO_W-1:0];
                end
                tbcfr_pkg::CFG_STEP_Q16: begin
                    r_cfg.step_q16 <= i_cfg_data[tbcfr_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ----- rtl/tbcfr_decode.sv -----
`default_nettype none

module tbcfr_decode (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_commit,
    input  wire logic [tbcfr_pkg::BYTE_W-1:0]     i_byte,
    input  wire tbcfr_pkg::t_cfg                  i_cfg,
    output tbcfr_pkg::t_result                    o_result
);

    logic                               r_held_count;
    logic [tbcfr_pkg::BYTE_W-1:0]       r_held_byte;
    logic                               r_start_seen;
    logic [tbcfr_pkg::COUNT_W-1:0]      r_packet_cnt;
    logic [tbcfr_pkg::COUNT_W-1:0]      r_message_cnt;
    logic [tbcfr_pkg::COUNT_W-1:0]      r_incomplete_cnt;
    logic [tbcfr_pkg::COUNT_W-1:0]      r_wrong_cnt;

    logic                               n_held_count;
    logic [tbcfr_pkg::BYTE_W-1:0]       n_held_byte;
    logic                               n_start_seen;
    logic [tbcfr_pkg::COUNT_W-1:0]      n_packet_cnt;
    logic [tbcfr_pkg::COUNT_W-1:0]      n_message_cnt;
    logic [tbcfr_pkg::COUNT_W-1:0]      n_incomplete_cnt;
    logic [tbcfr_pkg::COUNT_W-1:0]      n_wrong_cnt;

    logic                               is_start;
    logic                               start_eff;
    logic                               check_ok;
    logic [tbcfr_pkg::POINT_W-1:0]      point;
    logic signed [11:0]                 diff;
    logic signed [36:0]                 prod;

    assign is_start  = (i_byte & i_cfg.framing_mask) == '0;
    assign start_eff = is_start || r_start_seen;
    assign check_ok  = (i_byte[7:4] ^ r_held_byte[4:1]) == tbcfr_pkg::CHECK_MATCH;
    assign point     = {i_byte[7:1], r_held_byte[7:5]};
    // twice the point less the zero point, in half steps
    assign diff      = $signed({1'b0, point, 1'b0}) - $signed({1'b0, i_cfg.zero_point_x2});
    assign prod      = diff * $signed({1'b0, i_cfg.step_q16});

    always_comb begin
        n_held_count     = r_held_count;
        n_held_byte      = r_held_byte;
        n_start_seen     = r_start_seen;
        n_packet_cnt     = r_packet_cnt + 1'b1;
        n_message_cnt    = r_message_cnt;
        n_incomplete_cnt = r_incomplete_cnt;
        n_wrong_cnt      = r_wrong_cnt;

        o_result               = '0;
        o_result.outcome       = tbcfr_pkg::OUTCOME_INCOMPLETE;

        if (is_start && r_held_count) begin
            n_incomplete_cnt = r_incomplete_cnt + 1'b1;
        end

        if (!r_held_count || is_start) begin
            n_held_byte  = i_byte;
            n_held_count = 1'b1;
            n_start_seen = start_eff;
        end else begin
            o_result.first_packet  = r_held_byte;
            o_result.second_packet = i_byte;
            if (r_start_seen) begin
                if (check_ok) begin
                    o_result.outcome     = tbcfr_pkg::OUTCOME_OK;
                    o_result.scale_point = point;
                    o_result.current_q16 = prod[36:1];
                end else begin
                    o_result.outcome = tbcfr_pkg::OUTCOME_BAD_CHECK;
                    n_wrong_cnt      = r_wrong_cnt + 1'b1;
                end
            end else begin
                o_result.outcome = tbcfr_pkg::OUTCOME_NO_START;
            end
            n_message_cnt = r_message_cnt + 1'b1;
            n_held_count  = 1'b0;
            n_start_seen  = 1'b0;
        end

        o_result.packet_total     = n_packet_cnt;
        o_result.message_total    = n_message_cnt;
        o_result.incomplete_total = n_incomplete_cnt;
        o_result.wrong_total      = n_wrong_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count     <= 1'b0;
            r_held_byte      <= '0;
            r_start_seen     <= 1'b0;
            r_packet_cnt     <= '0;
            r_message_cnt    <= '0;
            r_incomplete_cnt <= '0;
            r_wrong_cnt      <= '0;
        end else if (i_commit) begin
            r_held_count     <= n_held_count;
            r_held_byte      <= n_held_byte;
            r_start_seen     <= n_start_seen;
            r_packet_cnt     <= n_packet_cnt;
            r_message_cnt    <= n_message_cnt;
            r_incomplete_cnt <= n_incomplete_cnt;
            r_wrong_cnt      <= n_wrong_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam logic [tbcfr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_WORDS = 255;
    localparam int N_PHASES    = 6;
    localparam logic [7:0] READY_PATTERN = 8'b1011_0010;

    typedef enum bit {ROW_SEND, ROW_WRITE} t_row_kind;

    typedef struct packed {
        bit                                     pin_oc;
        tbcfr_pkg::t_outcome                    oc;
        bit                                     pin_cur;
        logic signed [tbcfr_pkg::CURRENT_W-1:0] cur;
    } t_pin;

    localparam t_pin NO_PIN = '0;

    typedef struct {
        t_row_kind                              kind;
        logic [tbcfr_pkg::CFG_IDX_W-1:0]        idx;
        logic [tbcfr_pkg::CFG_DATA_W-1:0]       data;
        bit                                     pin_oc;
        tbcfr_pkg::t_outcome                    oc;
        bit                                     pin_cur;
        logic signed [tbcfr_pkg::CURRENT_W-1:0] cur;
    } t_row;

    typedef struct {
        tbcfr_pkg::t_result status;
        t_pin               pin;
    } t_expected;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    // rx_byte
    logic [tbcfr_pkg::BYTE_W-1:0]     s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    // outcome, first_packet, second_packet, scale_point, current_q16,
    // packet_total, message_total, incomplete_total, wrong_total
    logic [tbcfr_pkg::RESULT_W-1:0]   m_axis_tdata;
    logic                             i_cfg_we;
    logic [tbcfr_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tbcfr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    two_byte_current_frame_receiver uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // frame decoder state and register copy
    logic [tbcfr_pkg::BYTE_W-1:0]  cfg_mask;
    logic [tbcfr_pkg::ZERO_W-1:0]  cfg_zero;
    logic [tbcfr_pkg::STEP_W-1:0]  cfg_step;
    bit                            half_full;
    logic [tbcfr_pkg::BYTE_W-1:0]  kept_byte;
    bit                            framed;
    logic [tbcfr_pkg::COUNT_W-1:0] n_bytes, n_messages, n_cut, n_wrong;

    t_expected pending_status [$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        words_sent = 0;
    int        settings_used = 0;
    int        outcome_seen [4] = '{0, 0, 0, 0};
    int        burst_left = 0;
    int        idle_cycles = 0;
    bit        hold_req = 1'b0;

    t_row script [$] = '{
        '{ROW_SEND, CFG_SPARE, 24'h00, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hF1, 1'b1, tbcfr_pkg::OUTCOME_OK, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hE0, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hFF, 1'b1, tbcfr_pkg::OUTCOME_OK, 1'b1, 36'sd33521664},
        '{ROW_SEND, CFG_SPARE, 24'h1E, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h01, 1'b1, tbcfr_pkg::OUTCOME_OK, 1'b1, -36'sd33521664},
        '{ROW_SEND, CFG_SPARE, 24'h00, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h01, 1'b1, tbcfr_pkg::OUTCOME_BAD_CHECK, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h02, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h02, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hE1, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h03, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hFF, 1'b1, tbcfr_pkg::OUTCOME_NO_START, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h55, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h54, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h51, 1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, CFG_SPARE, 24'hFFFFFF,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, tbcfr_pkg::CFG_FRAMING_MASK, 24'h00,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hFF, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h00, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hAA, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, tbcfr_pkg::CFG_FRAMING_MASK, 24'hFF,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, tbcfr_pkg::CFG_ZERO_POINT_X2, 24'd0,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, tbcfr_pkg::CFG_STEP_Q16, 24'hFFFFFF,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h00, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'hFF,
          1'b1, tbcfr_pkg::OUTCOME_OK, 1'b1, 36'sd17045650440},
        '{ROW_WRITE, tbcfr_pkg::CFG_FRAMING_MASK, 24'h01,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, tbcfr_pkg::CFG_ZERO_POINT_X2, 24'd2047,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h1E, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h01,
          1'b1, tbcfr_pkg::OUTCOME_OK, 1'b1, -36'sd17171479553},
        '{ROW_WRITE, tbcfr_pkg::CFG_ZERO_POINT_X2, 24'd1,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_WRITE, tbcfr_pkg::CFG_STEP_Q16, 24'd1,
          1'b0, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h1E, 1'b1, tbcfr_pkg::OUTCOME_INCOMPLETE, 1'b0, 36'sd0},
        '{ROW_SEND, CFG_SPARE, 24'h01, 1'b1, tbcfr_pkg::OUTCOME_OK, 1'b1, -36'sd1}
    };

    function automatic void set_register(input logic [tbcfr_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [tbcfr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tbcfr_pkg::CFG_FRAMING_MASK:  cfg_mask = data[tbcfr_pkg::BYTE_W-1:0];
            tbcfr_pkg::CFG_ZERO_POINT_X2: cfg_zero = data[tbcfr_pkg::ZERO_W-1:0];
            tbcfr_pkg::CFG_STEP_Q16:      cfg_step = data[tbcfr_pkg::STEP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic tbcfr_pkg::t_result decode_byte(
            input logic [tbcfr_pkg::BYTE_W-1:0] b);
        tbcfr_pkg::t_result            r;
        logic [tbcfr_pkg::POINT_W-1:0] point;
        longint                        prod;
        r = '0;
        r.outcome = tbcfr_pkg::OUTCOME_INCOMPLETE;
        n_bytes++;
        // a start byte drops any half-gathered message
        if ((b & cfg_mask) == '0) begin
            if (half_full)
                n_cut++;
            half_full = 1'b0;
            framed = 1'b1;
        end
        if (!half_full) begin
            kept_byte = b;
            half_full = 1'b1;
        end else begin
            r.first_packet = kept_byte;
            r.second_packet = b;
            if (!framed) begin
                r.outcome = tbcfr_pkg::OUTCOME_NO_START;
            end else if ((b[7:4] ^ kept_byte[4:1]) != tbcfr_pkg::CHECK_MATCH) begin
                n_wrong++;
                r.outcome = tbcfr_pkg::OUTCOME_BAD_CHECK;
            end else begin
                point = {b[7:1], kept_byte[7:5]};
                prod = (2 * longint'(point) - longint'(cfg_zero)) * longint'(cfg_step);
                prod = prod >>> 1;
                r.scale_point = point;
                r.current_q16 = prod[tbcfr_pkg::CURRENT_W-1:0];
                r.outcome = tbcfr_pkg::OUTCOME_OK;
            end
            n_messages++;
            half_full = 1'b0;
            framed = 1'b0;
        end
        r.packet_total = n_bytes;
        r.message_total = n_messages;
        r.incomplete_total = n_cut;
        r.wrong_total = n_wrong;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            flag_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endtask

    task automatic check_status(input tbcfr_pkg::t_result got);
        t_expected e;
        results_seen++;
        outcome_seen[got.outcome]++;
        if (pending_status.size() == 0) begin
            flag_mismatch($sformatf("status word with nothing pending: %h", got));
            return;
        end
        e = pending_status.pop_front();
        check_field("outcome", e.status.outcome, got.outcome);
        check_field("first_packet", e.status.first_packet, got.first_packet);
        check_field("second_packet", e.status.second_packet, got.second_packet);
        check_field("scale_point", e.status.scale_point, got.scale_point);
        check_field("current_q16", e.status.current_q16, got.current_q16);
        check_field("packet_total", e.status.packet_total, got.packet_total);
        check_field("message_total", e.status.message_total, got.message_total);
        check_field("incomplete_total", e.status.incomplete_total, got.incomplete_total);
        check_field("wrong_total", e.status.wrong_total, got.wrong_total);
        if (e.pin.pin_oc)
            check_field("outcome (table)", e.pin.oc, got.outcome);
        if (e.pin.pin_cur)
            check_field("current_q16 (table)", e.pin.cur, got.current_q16);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_status(tbcfr_pkg::t_result'(m_axis_tdata));
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // receiver: ready runs through always-on, random and fixed-pattern phases, long hold-off on request
    initial begin
        int cyc;
        cyc = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                case (cyc[7:6])
                    2'd0:    m_axis_tready <= 1'b1;
                    2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                    2'd2:    m_axis_tready <= ($urandom_range(0, 9) < 3);
                    default: m_axis_tready <= READY_PATTERN[cyc[2:0]];
                endcase
            end
        end
    end

    task automatic send_word(input logic [tbcfr_pkg::BYTE_W-1:0] b, input t_pin pin);
        int        gap;
        t_expected e;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        e.status = decode_byte(b);
        e.pin = pin;
        pending_status.push_back(e);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tbcfr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbcfr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        set_register(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int                           n;
        int                           r;
        logic [tbcfr_pkg::BYTE_W-1:0] head, tail;
        logic [tbcfr_pkg::BYTE_W-1:0] mask_v;
        logic [tbcfr_pkg::ZERO_W-1:0] zero_v;
        logic [tbcfr_pkg::STEP_W-1:0] step_v;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tbcfr_pkg::CFG_FRAMING_MASK;
        i_cfg_data = '0;
        cfg_mask = tbcfr_pkg::FRAMING_MASK_RST;
        cfg_zero = tbcfr_pkg::ZERO_POINT_X2_RST;
        cfg_step = tbcfr_pkg::STEP_Q16_RST;
        half_full = 1'b0;
        kept_byte = '0;
        framed = 1'b0;
        n_bytes = '0;
        n_messages = '0;
        n_cut = '0;
        n_wrong = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            if (script[k].kind == ROW_WRITE) begin
                settle();
                write_reg(script[k].idx, script[k].data);
            end else begin
                send_word(script[k].data[tbcfr_pkg::BYTE_W-1:0],
                          '{script[k].pin_oc, script[k].oc, script[k].pin_cur, script[k].cur});
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            if (p == 0) begin
                mask_v = tbcfr_pkg::FRAMING_MASK_RST;
                zero_v = tbcfr_pkg::ZERO_POINT_X2_RST;
                step_v = tbcfr_pkg::STEP_Q16_RST;
            end else if (p == 1) begin
                mask_v = 8'h80;
                zero_v = 11'd2046;
                step_v = '0;
            end else begin
                case ($urandom_range(0, 5))
                    0:       mask_v = 8'h01;
                    1:       mask_v = 8'hFF;
                    default: mask_v = 8'($urandom_range(1, 255));
                endcase
                case ($urandom_range(0, 3))
                    0:       zero_v = 11'd0;
                    1:       zero_v = 11'd2046;
                    2:       zero_v = 11'd2047;
                    default: zero_v = 11'($urandom_range(0, 2047));
                endcase
                case ($urandom_range(0, 3))
                    0:       step_v = 24'hFFFFFF;
                    1:       step_v = '0;
                    default: step_v = 24'($urandom_range(0, 24'hFFFFFF));
                endcase
            end
            write_reg(tbcfr_pkg::CFG_FRAMING_MASK, {16'd0, mask_v});
            write_reg(tbcfr_pkg::CFG_ZERO_POINT_X2, {13'd0, zero_v});
            write_reg(tbcfr_pkg::CFG_STEP_Q16, step_v);
            settings_used++;
            // block fills up while the sender keeps offering
            if (p == 2)
                hold_req = 1'b1;
            n = 0;
            while (n < PHASE_WORDS) begin
                r = $urandom_range(0, 9);
                head = 8'($urandom_range(0, 255)) & ~cfg_mask;
                if (r < 8) begin
                    if (r < 7)
                        tail = {~head[4:1], 4'($urandom_range(0, 15))};
                    else
                        tail = 8'($urandom_range(0, 255));
                    if ((tail & cfg_mask) == '0)
                        tail[3:0] = tail[3:0] | cfg_mask[3:0];
                    send_word(head, NO_PIN);
                    send_word(tail, NO_PIN);
                    n += 2;
                end else if (r == 8) begin
                    send_word(8'($urandom_range(0, 255)), NO_PIN);
                    n++;
                end else begin
                    // start cut short by another start
                    send_word(head, NO_PIN);
                    send_word(8'($urandom_range(0, 255)) & ~cfg_mask, NO_PIN);
                    n += 2;
                end
            end
        end

        settle();
        $display("tb_top: %0d words sent, %0d status words checked, %0d settings, %0d mismatches",
                 words_sent, results_seen, settings_used + 5, mismatches);
        $display("tb_top: ok %0d, check failed %0d, no start %0d, incomplete %0d",
                 outcome_seen[tbcfr_pkg::OUTCOME_OK],
                 outcome_seen[tbcfr_pkg::OUTCOME_BAD_CHECK],
                 outcome_seen[tbcfr_pkg::OUTCOME_NO_START],
                 outcome_seen[tbcfr_pkg::OUTCOME_INCOMPLETE]);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
